// ===== hdl/gregorian_day_number_converter_top_macros.svh =====
// Assertion macros used by the converter's checker.
`ifndef GREGORIAN_DAY_NUMBER_CONVERTER_TOP_MACROS_SVH
`define GREGORIAN_DAY_NUMBER_CONVERTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDNC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GDNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/gdnc_pkg.sv =====
// Shared widths, codes, types and calendar tables of the day number converter.
`timescale 1ns / 1ps
package gdnc_pkg;

	localparam int unsigned SERIAL_W = 22;
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;

	// Command codes.
	localparam logic CMD_TO_SERIAL = 1'b0;
	localparam logic CMD_TO_DATE   = 1'b1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_YEAR  = 4'b0010,
		ST_MONTH = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	// Year decomposition phases: 400, 100, 4 and 1 year blocks.
	typedef logic [1:0] phase_t;
	localparam phase_t PH_400 = 2'd0;
	localparam phase_t PH_100 = 2'd1;
	localparam phase_t PH_4   = 2'd2;
	localparam phase_t PH_1   = 2'd3;

	typedef logic [SERIAL_W-1:0] word_t;

	// Number of years in one block of the given phase.
	function automatic word_t year_units(input phase_t ph);
		word_t r;
		case (ph)
			PH_400:  r = 22'd400;
			PH_100:  r = 22'd100;
			PH_4:    r = 22'd4;
			PH_1:    r = 22'd1;
			default: r = 22'd1;
		endcase
		return r;
	endfunction

	// Number of days in one block of the given phase.
	function automatic word_t day_units(input phase_t ph);
		word_t r;
		case (ph)
			PH_400:  r = 22'd146097;
			PH_100:  r = 22'd36524;
			PH_4:    r = 22'd1461;
			PH_1:    r = 22'd365;
			default: r = 22'd365;
		endcase
		return r;
	endfunction

	// Length of a month, with February depending on the leap flag.
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] r;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			4'd2:                    r = leap ? 5'd29 : 5'd28;
			default:                 r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/gregorian_day_number_converter_top.sv =====
// Proleptic Gregorian date to serial day number converter, both directions.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+---------------------------------------------
//  input   | in_valid / in_ready     | cmd, in_year, in_month, in_day, in_serial
//  output  | out_valid / out_ready   | out_serial, out_year, out_month, out_day,
//          |                         | range_error
//
// An item passes through the transfer, one step per 400, 100, 4 and 1 year block peeled
// off plus one exit per phase, one step per month stepped and the load of the output
// register, all on one shared subtract/compare and one adder; a range error goes from the
// transfer straight to the output load. in_ready is high only while the sequencer is idle; a
// result waiting in the output register does not block the next transfer, but a finished
// item waits for it to drain. Reset is asynchronous and clears the sequencer and out_valid.
`timescale 1ns / 1ps
module gregorian_day_number_converter_top #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [gdnc_pkg::YEAR_W-1:0]    in_year,
	input  logic [gdnc_pkg::MONTH_W-1:0]   in_month,
	input  logic [gdnc_pkg::DAY_W-1:0]     in_day,
	input  logic [gdnc_pkg::SERIAL_W-1:0]  in_serial,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gdnc_pkg::SERIAL_W-1:0]  out_serial,
	output logic [gdnc_pkg::YEAR_W-1:0]    out_year,
	output logic [gdnc_pkg::MONTH_W-1:0]   out_month,
	output logic [gdnc_pkg::DAY_W-1:0]     out_day,
	output logic                           range_error
);
	import gdnc_pkg::*;

	// Serial number of December 31 of the last valid year.
	localparam int unsigned MAX_SERIAL =
		MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

	state_t               state_q;
	phase_t               ph_q;
	logic [4:0]           cnt_q;
	logic                 cmd_q;
	logic                 err_q;
	logic [MONTH_W-1:0]   mon_lim_q;
	logic [DAY_W-1:0]     day_q;
	word_t                rem_q;
	word_t                acc_q;
	logic [1:0]           n100_q;
	logic [4:0]           n4_q;
	logic [1:0]           n1_q;
	logic [MONTH_W-1:0]   m_q;
	logic                 out_valid_q;
	logic [SERIAL_W-1:0]  out_serial_q;
	logic [YEAR_W-1:0]    out_year_q;
	logic [MONTH_W-1:0]   out_month_q;
	logic [DAY_W-1:0]     out_day_q;
	logic                 range_error_q;

	logic                 accept;
	logic                 load_out;
	logic                 in_error;
	logic                 leap;
	logic                 capped;
	logic                 fits;
	logic                 month_more;
	word_t                dim;
	word_t                sub_op;
	word_t                add_op;
	word_t                sum;
	logic [SERIAL_W:0]    diff;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Range check of the operands of the selected command.
	always_comb begin
		if (cmd == CMD_TO_SERIAL) begin
			in_error = (in_year == '0) || (in_year > YEAR_W'(MAX_YEAR)) ||
				(in_month == '0) || (in_month > 4'd12) || (in_day == '0);
		end else begin
			in_error = (in_serial == '0) || (in_serial > SERIAL_W'(MAX_SERIAL));
		end
	end

	// Leap year from the block counts of year minus one.
	assign leap       = (n1_q == 2'd3) && ((n4_q != 5'd24) || (n100_q == 2'd3));
	assign dim        = SERIAL_W'(month_days(m_q, leap));
	assign capped     = ((ph_q == PH_100) || (ph_q == PH_1)) && (cnt_q == 5'd3);
	assign month_more = (m_q < mon_lim_q);

	// Operand selection for the shared subtractor and adder.
	always_comb begin
		if (state_q == ST_MONTH) begin
			sub_op = dim;
			add_op = month_more ? dim : SERIAL_W'(day_q);
		end else if (cmd_q == CMD_TO_DATE) begin
			sub_op = day_units(ph_q);
			add_op = year_units(ph_q);
		end else begin
			sub_op = year_units(ph_q);
			add_op = day_units(ph_q);
		end
	end

	assign diff = {1'b0, rem_q} - {1'b0, sub_op};
	assign fits = !diff[SERIAL_W];
	assign sum  = acc_q + add_op;

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= in_error ? ST_DONE : ST_YEAR;
					end
				end
				ST_YEAR: begin
					if (!(fits && !capped) && (ph_q == PH_1)) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if (cmd_q == CMD_TO_SERIAL) begin
						if (!month_more) begin
							state_q <= ST_DONE;
						end
					end else if (!((m_q < 4'd12) && fits)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, loaded on a transfer and stepped by the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q     <= cmd;
					err_q     <= in_error;
					mon_lim_q <= in_month;
					day_q     <= in_day;
					acc_q     <= '0;
					ph_q      <= PH_400;
					cnt_q     <= '0;
					m_q       <= 4'd1;
					if (cmd == CMD_TO_DATE) begin
						rem_q <= in_serial - 22'd1;
					end else begin
						rem_q <= SERIAL_W'(in_year) - 22'd1;
					end
				end
			end
			ST_YEAR: begin
				if (fits && !capped) begin
					rem_q <= diff[SERIAL_W-1:0];
					acc_q <= sum;
					cnt_q <= cnt_q + 5'd1;
				end else begin
					case (ph_q)
						PH_100:  n100_q <= cnt_q[1:0];
						PH_4:    n4_q   <= cnt_q;
						PH_1:    n1_q   <= cnt_q[1:0];
						default: ;
					endcase
					cnt_q <= '0;
					ph_q  <= ph_q + 2'd1;
					m_q   <= 4'd1;
				end
			end
			ST_MONTH: begin
				if (cmd_q == CMD_TO_SERIAL) begin
					acc_q <= sum;
					if (month_more) begin
						m_q <= m_q + 4'd1;
					end
				end else if ((m_q < 4'd12) && fits) begin
					rem_q <= diff[SERIAL_W-1:0];
					m_q   <= m_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	// Output register, loaded when the finished result can be moved out.
	always_ff @(posedge clk) begin
		if (load_out) begin
			range_error_q <= err_q;
			out_serial_q  <= '0;
			out_year_q    <= '0;
			out_month_q   <= '0;
			out_day_q     <= '0;
			if (!err_q) begin
				if (cmd_q == CMD_TO_SERIAL) begin
					out_serial_q <= acc_q;
				end else begin
					out_year_q  <= acc_q[YEAR_W-1:0] + 14'd1;
					out_month_q <= m_q;
					out_day_q   <= rem_q[DAY_W-1:0] + 5'd1;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_serial  = out_serial_q;
	assign out_year    = out_year_q;
	assign out_month   = out_month_q;
	assign out_day     = out_day_q;
	assign range_error = range_error_q;

endmodule

// ===== hdl/gdnc_checker.sv =====
// Port-level checker for the day number converter and its bind statement.
`timescale 1ns / 1ps
`include "gregorian_day_number_converter_top_macros.svh"
module gdnc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [gdnc_pkg::SERIAL_W-1:0]  out_serial,
	input logic [gdnc_pkg::YEAR_W-1:0]    out_year,
	input logic [gdnc_pkg::MONTH_W-1:0]   out_month,
	input logic [gdnc_pkg::DAY_W-1:0]     out_day,
	input logic                           range_error
);
	import gdnc_pkg::*;

	// A range error clears every result field.
	`GDNC_ASSERT_NOW(a_err_zero, clk, arst_n, out_valid && range_error, (out_serial == '0) && (out_year == '0) && (out_month == '0) && (out_day == '0), "range error with nonzero result")

	// A date result carries a real month and day.
	`GDNC_ASSERT_NOW(a_date_ok, clk, arst_n, out_valid && !range_error && (out_serial == '0), (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day != '0), "date result out of range")

	// The converter is busy in the cycle after an input transfer.
	`GDNC_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready, "ready right after a transfer")

	// No result can appear in the cycle after an input transfer.
	`GDNC_ASSERT_NEXT(a_no_early, clk, arst_n, in_valid && in_ready, !$rose(out_valid), "result too early")

	// A stalled result stays valid and keeps its serial, year and day.
	`GDNC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_serial) && $stable(out_year) && $stable(out_day), "stalled result changed")

endmodule

bind gregorian_day_number_converter_top gdnc_checker u_gdnc_checker (.*);

// ===== bench/gregorian_day_number_converter_top_tb.sv =====
// Self-checking testbench for the Gregorian date and serial day number converter.
`timescale 1ns / 1ps
module gregorian_day_number_converter_top_tb;
	import gdnc_pkg::*;

	localparam int unsigned CAL_MAX_YEAR = 9999;
	localparam int unsigned LAST_SERIAL  = CAL_MAX_YEAR * 365 + CAL_MAX_YEAR / 4
		- CAL_MAX_YEAR / 100 + CAL_MAX_YEAR / 400;
	localparam int unsigned RANDOM_ITEMS = 700;
	localparam int unsigned QUIET_ITEMS  = 100;
	localparam int unsigned TAIL_CYCLES  = 100;
	localparam int unsigned TIMEOUT_NS   = 6_000_000;

	typedef struct packed {
		logic                cmd;
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [SERIAL_W-1:0] serial;
	} date_request_t;

	typedef struct packed {
		logic [SERIAL_W-1:0] serial;
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic                flag;
	} date_result_t;

	typedef struct packed {
		date_request_t req;
		logic          known;
		date_result_t  want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                cmd = CMD_TO_SERIAL;
	logic [YEAR_W-1:0]   in_year = '0;
	logic [MONTH_W-1:0]  in_month = '0;
	logic [DAY_W-1:0]    in_day = '0;
	logic [SERIAL_W-1:0] in_serial = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SERIAL_W-1:0] out_serial;
	logic [YEAR_W-1:0]   out_year;
	logic [MONTH_W-1:0]  out_month;
	logic [DAY_W-1:0]    out_day;
	logic                range_error;

	date_result_t pending_results[$];
	date_result_t oldest_result;
	stim_row_t    stim_table[$];
	bit           quiet_tail = 1'b0;
	int unsigned  mismatches = 0;
	int unsigned  n_to_serial = 0;
	int unsigned  n_to_date = 0;
	int unsigned  n_out_of_range = 0;
	int unsigned  n_checked = 0;

	gregorian_day_number_converter_top #(
		.MAX_YEAR(CAL_MAX_YEAR)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.in_year(in_year),
		.in_month(in_month),
		.in_day(in_day),
		.in_serial(in_serial),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_serial(out_serial),
		.out_year(out_year),
		.out_month(out_month),
		.out_day(out_day),
		.range_error(range_error)
	);

	// 12 ns clock.
	always #6 clk = ~clk;

	// Calendar arithmetic for the expected results.
	function automatic bit is_leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
		int unsigned len;
		case (m)
			4, 6, 9, 11: len = 30;
			2:           len = is_leap_year(y) ? 29 : 28;
			default:     len = 31;
		endcase
		return len;
	endfunction

	// Days in all the years that come before year y.
	function automatic int unsigned days_ahead_of_year(input int unsigned y);
		int unsigned p;
		p = y - 1;
		return p * 365 + p / 4 - p / 100 + p / 400;
	endfunction

	function automatic int unsigned year_length(input int unsigned y);
		return is_leap_year(y) ? 366 : 365;
	endfunction

	// Expected result of one request in either direction.
	function automatic date_result_t convert_date(input date_request_t r);
		date_result_t res;
		int unsigned  total;
		int unsigned  rest;
		int unsigned  y;
		int unsigned  m;
		res = '0;
		if (r.cmd == CMD_TO_SERIAL) begin
			if (r.year < 1 || r.year > CAL_MAX_YEAR || r.month < 1 || r.month > 12
					|| r.day < 1) begin
				res.flag = 1'b1;
			end else begin
				// Days past the end of the month simply run on into the next one.
				total = days_ahead_of_year(32'(r.year)) + r.day;
				for (m = 1; m < r.month; m++)
					total += month_length(32'(r.year), m);
				res.serial = SERIAL_W'(total);
			end
		end else begin
			if (r.serial < 1 || r.serial > LAST_SERIAL) begin
				res.flag = 1'b1;
			end else begin
				// Skip whole 400 year cycles, then walk year by year and month by month.
				rest = r.serial - 1;
				y = 400 * (rest / 146097);
				rest = rest % 146097;
				while (rest >= year_length(y + 1)) begin
					rest -= year_length(y + 1);
					y++;
				end
				y++;
				m = 1;
				while (m < 12 && rest >= month_length(y, m)) begin
					rest -= month_length(y, m);
					m++;
				end
				res.year = YEAR_W'(y);
				res.month = MONTH_W'(m);
				res.day = DAY_W'(rest + 1);
			end
		end
		return res;
	endfunction

	// Table rows: one checked against the predictor, one with its result typed in.
	function automatic stim_row_t predicted_row(input logic c, input logic [YEAR_W-1:0] y,
			input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
			input logic [SERIAL_W-1:0] s);
		stim_row_t row;
		row = '0;
		row.req = '{cmd: c, year: y, month: m, day: d, serial: s};
		return row;
	endfunction

	function automatic stim_row_t known_row(input logic c, input logic [YEAR_W-1:0] y,
			input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
			input logic [SERIAL_W-1:0] s, input logic [SERIAL_W-1:0] es,
			input logic [YEAR_W-1:0] ey, input logic [MONTH_W-1:0] em,
			input logic [DAY_W-1:0] ed, input logic ef);
		stim_row_t row;
		row.req = '{cmd: c, year: y, month: m, day: d, serial: s};
		row.known = 1'b1;
		row.want = '{serial: es, year: ey, month: em, day: ed, flag: ef};
		return row;
	endfunction

	// Mostly well-formed requests with a lean toward leap and century boundaries,
	// the rest fully random noise. Unused fields always carry random junk.
	function automatic date_request_t random_request();
		date_request_t r;
		int unsigned   kind;
		int unsigned   y;
		kind = $urandom_range(0, 99);
		r.cmd = 1'($urandom);
		r.year = YEAR_W'($urandom);
		r.month = MONTH_W'($urandom);
		r.day = DAY_W'($urandom);
		r.serial = SERIAL_W'($urandom);
		if (kind < 80) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 11))
					0:       y = 1;
					1:       y = 4;
					2:       y = 99;
					3:       y = 100;
					4:       y = 399;
					5:       y = 400;
					6:       y = 1900;
					7:       y = 2000;
					8:       y = 2100;
					9:       y = 9996;
					10:      y = CAL_MAX_YEAR;
					default: y = CAL_MAX_YEAR - 1;
				endcase
			end else begin
				y = $urandom_range(1, CAL_MAX_YEAR);
			end
			if (kind < 45) begin
				r.cmd = CMD_TO_SERIAL;
				r.year = YEAR_W'(y);
				r.month = MONTH_W'($urandom_range(1, 12));
				r.day = DAY_W'($urandom_range(1, 31));
			end else begin
				r.cmd = CMD_TO_DATE;
				case ($urandom_range(0, 5))
					0:       r.serial = SERIAL_W'(days_ahead_of_year(y) + $urandom_range(1, 62));
					1:       r.serial = SERIAL_W'(days_ahead_of_year(y + 1) - $urandom_range(0, 1));
					default: r.serial = SERIAL_W'($urandom_range(1, LAST_SERIAL));
				endcase
			end
		end
		return r;
	endfunction

	// Present one request and hold it until the transfer happens.
	task automatic send_request(input date_request_t r, input date_result_t want);
		in_valid <= 1'b1;
		cmd <= r.cmd;
		in_year <= r.year;
		in_month <= r.month;
		in_day <= r.day;
		in_serial <= r.serial;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(want);
		if (r.cmd == CMD_TO_SERIAL)
			n_to_serial++;
		else
			n_to_date++;
		if (want.flag)
			n_out_of_range++;
	endtask

	// Random burst of idle cycles on the input side.
	task automatic sender_pause(input int unsigned pct);
		if ($urandom_range(1, 100) <= pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10))
				@(posedge clk);
		end
	endtask

	task automatic await_all_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Result side: every transfer is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: serial %0d, date %0d-%0d-%0d, range_error %0b",
					out_serial, out_year, out_month, out_day, range_error);
				mismatches++;
			end else begin
				oldest_result = pending_results.pop_front();
				compare_field("out_serial", 32'(oldest_result.serial), 32'(out_serial));
				compare_field("out_year", 32'(oldest_result.year), 32'(out_year));
				compare_field("out_month", 32'(oldest_result.month), 32'(out_month));
				compare_field("out_day", 32'(oldest_result.day), 32'(out_day));
				compare_field("range_error", 32'(oldest_result.flag), 32'(range_error));
				n_checked++;
			end
		end
	end

	// Receiver stalls in bursts, with occasional long calm stretches.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!quiet_tail && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10))
					@(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
			if (!quiet_tail && $urandom_range(0, 7) == 0)
				repeat (200)
					@(posedge clk);
		end
	end

	// Stimulus: directed table, then random requests, then the drain.
	initial begin
		date_request_t req;
		int unsigned   idle_pct;
		idle_pct = 30;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Date to serial: extremes, each rejected field, leap and rollover cases.
		stim_table.push_back(known_row(CMD_TO_SERIAL, 1, 1, 1, 0, 1, 0, 0, 0, 0));
		stim_table.push_back(known_row(CMD_TO_SERIAL, YEAR_W'(CAL_MAX_YEAR), 12, 31, 0,
			SERIAL_W'(LAST_SERIAL), 0, 0, 0, 0));
		stim_table.push_back(known_row(CMD_TO_SERIAL, 0, 6, 15, 0, 0, 0, 0, 0, 1));
		stim_table.push_back(known_row(CMD_TO_SERIAL, 10000, 1, 1, 0, 0, 0, 0, 0, 1));
		stim_table.push_back(known_row(CMD_TO_SERIAL, 16383, 15, 31, 0, 0, 0, 0, 0, 1));
		stim_table.push_back(known_row(CMD_TO_SERIAL, 2024, 0, 10, 0, 0, 0, 0, 0, 1));
		stim_table.push_back(known_row(CMD_TO_SERIAL, 2024, 13, 10, 0, 0, 0, 0, 0, 1));
		stim_table.push_back(known_row(CMD_TO_SERIAL, 2024, 7, 0, 0, 0, 0, 0, 0, 1));
		stim_table.push_back(predicted_row(CMD_TO_SERIAL, 2023, 2, 31, 0));
		stim_table.push_back(predicted_row(CMD_TO_SERIAL, 1900, 2, 29, 0));
		stim_table.push_back(predicted_row(CMD_TO_SERIAL, 2000, 2, 29, 0));
		stim_table.push_back(predicted_row(CMD_TO_SERIAL, 400, 12, 31, 0));
		stim_table.push_back(predicted_row(CMD_TO_SERIAL, YEAR_W'(CAL_MAX_YEAR), 2, 31,
			4194303));
		stim_table.push_back(predicted_row(CMD_TO_SERIAL, 4, 12, 31, 0));
		// Serial to date: extremes, out of range values and cycle boundaries.
		stim_table.push_back(known_row(CMD_TO_DATE, 16383, 15, 31, 1, 0, 1, 1, 1, 0));
		stim_table.push_back(known_row(CMD_TO_DATE, 0, 0, 0, SERIAL_W'(LAST_SERIAL),
			0, YEAR_W'(CAL_MAX_YEAR), 12, 31, 0));
		stim_table.push_back(known_row(CMD_TO_DATE, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		stim_table.push_back(known_row(CMD_TO_DATE, 0, 0, 0, SERIAL_W'(LAST_SERIAL + 1),
			0, 0, 0, 0, 1));
		stim_table.push_back(known_row(CMD_TO_DATE, 0, 0, 0, 4194303, 0, 0, 0, 0, 1));
		stim_table.push_back(predicted_row(CMD_TO_DATE, 0, 0, 0, 146096));
		stim_table.push_back(predicted_row(CMD_TO_DATE, 0, 0, 0, 146097));
		stim_table.push_back(predicted_row(CMD_TO_DATE, 0, 0, 0, 146098));
		stim_table.push_back(predicted_row(CMD_TO_DATE, 0, 0, 0, 36524));
		stim_table.push_back(predicted_row(CMD_TO_DATE, 0, 0, 0, 36525));
		stim_table.push_back(predicted_row(CMD_TO_DATE, 0, 0, 0, 1461));

		foreach (stim_table[i]) begin
			send_request(stim_table[i].req, stim_table[i].known ? stim_table[i].want
				: convert_date(stim_table[i].req));
			sender_pause(idle_pct);
		end
		in_valid <= 1'b0;
		await_all_results();

		// Random part; idling varies per segment and stops for the final stretch.
		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0) begin
				case ($urandom_range(0, 2))
					0:       idle_pct = 0;
					1:       idle_pct = 20;
					default: idle_pct = 50;
				endcase
			end
			if (i == RANDOM_ITEMS - QUIET_ITEMS)
				quiet_tail = 1'b1;
			req = random_request();
			send_request(req, convert_date(req));
			if (i == RANDOM_ITEMS / 2) begin
				// Let the block run completely dry once.
				in_valid <= 1'b0;
				await_all_results();
			end else if (!quiet_tail) begin
				sender_pause(idle_pct);
			end
		end
		in_valid <= 1'b0;
		await_all_results();
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("Covered %0d date-to-serial and %0d serial-to-date requests, %0d out of range.",
			n_to_serial, n_to_date, n_out_of_range);
		$display("Checked %0d results field by field, %0d mismatches.", n_checked, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d results still outstanding.", pending_results.size());
		$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/gdnc_pkg.sv
hdl/gregorian_day_number_converter_top.sv
hdl/gdnc_checker.sv
bench/gregorian_day_number_converter_top_tb.sv
